// ===== rtl/rpq_pkg.sv =====
`default_nettype none
package rpq_pkg;

	// entries per parity store; a power of two, so the store index is the low position bits
	localparam int CHUNK_WORDS = 1024;
	localparam int ADDR_W      = $clog2(CHUNK_WORDS);

	localparam int POS_W       = 10;
	localparam int WORD_W      = 32;
	localparam int S_TDATA_W   = 48;   // word_position + data_word, padded to bytes
	localparam int M_TDATA_W   = 80;   // out_position + p_word + q_word, padded to bytes
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	localparam logic [7:0]  POLY_W8_RST  = 8'd29;
	localparam logic [15:0] POLY_W16_RST = 16'd4107;
	localparam logic [31:0] POLY_W32_RST = 32'd4194311;

	typedef enum logic [1:0] {
		MODE_W8  = 2'd0,
		MODE_W16 = 2'd1,
		MODE_W32 = 2'd2
	} gf_mode_t;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_POLY8  = 2'd1,
		REG_POLY16 = 2'd2,
		REG_POLY32 = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  poly8;
		logic [15:0] poly16;
		logic [31:0] poly32;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/raid6_pq_parity_encoder.sv =====
`default_nettype none
// RAID-6 P/Q parity encoder. Data chunks stream in chunk-major, one 32-bit word per item on
// the s_ side; s_tuser flags chunk zero and s_tlast flags the final chunk. P (plain XOR) and Q
// (Horner doubling over GF(2^8), GF(2^16) or GF(2^32) symbols, set by symbol_width_mode) are
// kept per word position in two 1024 x 32 single-port-write RAMs. Every item is one
// read-modify-write of both RAMs: the read is issued on accept, the update and write-back
// happen as it leaves stage 1, and a write to the same position in that cycle is forwarded. The
// block takes one item per clock; a final-chunk item moves from stage 1 into a single output
// register, which shows its P/Q on the m_ side; input stalls only while that register holds
// an untaken result and another final-chunk item waits behind it. The stores are not cleared:
// a later-chunk word must follow a chunk-zero word at the same position. Registers (APB,
// byte address 4*i): 0 symbol_width_mode [0], 1 poly_w8 [29], 2 poly_w16 [4107], 3 poly_w32
// [4194311]; write them only while the block is idle.
module raid6_pq_parity_encoder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// stream in
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	input  wire logic [rpq_pkg::S_TDATA_W-1:0]  s_tdata,  // [9:0] word_position, [41:10] data_word, [47:42] zero
	input  wire logic                           s_tlast,  // last_chunk
	input  wire logic                           s_tuser,  // first_chunk
	// stream out
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	output      logic [rpq_pkg::M_TDATA_W-1:0]  m_tdata,  // [9:0] out_position, [41:10] p_word, [73:42] q_word, [79:74] zero
	// config
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [rpq_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [rpq_pkg::PDATA_W-1:0]    pwdata,
	output      logic [rpq_pkg::PDATA_W-1:0]    prdata,
	output      logic                           pready
);

	rpq_pkg::cfg_t cfg;

	logic [rpq_pkg::POS_W-1:0]  in_pos;
	logic [rpq_pkg::WORD_W-1:0] in_data;
	logic                       s_acc;

	// stage 1: item whose RAM read is in flight / ready
	logic                       v_s1;
	logic [rpq_pkg::POS_W-1:0]  pos_s1;
	logic [rpq_pkg::WORD_W-1:0] data_s1;
	logic                       first_s1;
	logic                       last_s1;
	logic                       fwd_s1;
	logic [rpq_pkg::WORD_W-1:0] fwd_p_s1;
	logic [rpq_pkg::WORD_W-1:0] fwd_q_s1;

	logic                       adv;
	logic                       wr_en;
	logic                       fwd_hit;
	logic [rpq_pkg::WORD_W-1:0] p_rd, q_rd;
	logic [rpq_pkg::WORD_W-1:0] p_old, q_old;
	logic [rpq_pkg::WORD_W-1:0] p_new, q_new;

	// output register
	logic                       m_valid_q;
	logic [rpq_pkg::POS_W-1:0]  m_pos_q;
	logic [rpq_pkg::WORD_W-1:0] m_p_q;
	logic [rpq_pkg::WORD_W-1:0] m_q_q;

	assign in_pos  = s_tdata[rpq_pkg::POS_W-1:0];
	assign in_data = s_tdata[rpq_pkg::POS_W +: rpq_pkg::WORD_W];

	// non-final items always move on; final ones need room in the output register
	assign adv      = !last_s1 || !m_valid_q || m_tready;
	assign s_tready = !v_s1 || adv;
	assign s_acc    = s_tvalid && s_tready;
	assign wr_en    = v_s1 && adv;

	// RAM read of the new item races the write-back of the item ahead of it
	assign fwd_hit = wr_en
		&& (in_pos[rpq_pkg::ADDR_W-1:0] == pos_s1[rpq_pkg::ADDR_W-1:0]);

	rpq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rpq_ram #(
		.WIDTH (rpq_pkg::WORD_W),
		.DEPTH (rpq_pkg::CHUNK_WORDS)
	) u_p_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pos_s1[rpq_pkg::ADDR_W-1:0]),
		.wdata (p_new),
		.re    (s_acc),
		.raddr (in_pos[rpq_pkg::ADDR_W-1:0]),
		.rdata (p_rd)
	);

	rpq_ram #(
		.WIDTH (rpq_pkg::WORD_W),
		.DEPTH (rpq_pkg::CHUNK_WORDS)
	) u_q_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pos_s1[rpq_pkg::ADDR_W-1:0]),
		.wdata (q_new),
		.re    (s_acc),
		.raddr (in_pos[rpq_pkg::ADDR_W-1:0]),
		.rdata (q_rd)
	);

	assign p_old = fwd_s1 ? fwd_p_s1 : p_rd;
	assign q_old = fwd_s1 ? fwd_q_s1 : q_rd;

	rpq_gf u_gf (
		.cfg   (cfg),
		.first (first_s1),
		.data  (data_s1),
		.p_old (p_old),
		.q_old (q_old),
		.p_new (p_new),
		.q_new (q_new)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_acc;
		end
	end

	// stage 1 payload; the RAM read data holds while the item waits
	always_ff @(posedge clk) begin
		if (s_acc) begin
			pos_s1   <= in_pos;
			data_s1  <= in_data;
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
			fwd_s1   <= fwd_hit;
			fwd_p_s1 <= p_new;
			fwd_q_s1 <= q_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (wr_en && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && last_s1) begin
			m_pos_q <= pos_s1;
			m_p_q   <= p_new;
			m_q_q   <= q_new;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, m_q_q, m_p_q, m_pos_q};

	// a final-chunk item leaving stage 1 always lands in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv && last_s1) |=> m_valid_q)
		else $error("final-chunk item lost at output register");

	// input backs up only behind a blocked final-chunk result
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && last_s1 && m_valid_q && !m_tready))
		else $error("input stalled without cause");

	// a chunk-zero item writes the same word to both stores
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && first_s1) |-> (p_new == q_new))
		else $error("chunk-zero P/Q mismatch");

	// a waiting item keeps its position so the write-back address stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(pos_s1)))
		else $error("stalled item changed");

endmodule
`default_nettype wire

// ===== rtl/rpq_ram.sv =====
`default_nettype none
module rpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rpq_cfg.sv =====
`default_nettype none
module rpq_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rpq_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [rpq_pkg::PDATA_W-1:0]  pwdata,
	output      logic [rpq_pkg::PDATA_W-1:0]  prdata,
	output      logic                         pready,
	output      rpq_pkg::cfg_t                cfg
);

	rpq_pkg::cfg_t     cfg_q;
	rpq_pkg::reg_idx_t idx;
	logic              wr;

	assign pready = 1'b1;
	assign idx    = rpq_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= rpq_pkg::MODE_W8;
			cfg_q.poly8  <= rpq_pkg::POLY_W8_RST;
			cfg_q.poly16 <= rpq_pkg::POLY_W16_RST;
			cfg_q.poly32 <= rpq_pkg::POLY_W32_RST;
		end else if (wr) begin
			unique case (idx)
				rpq_pkg::REG_MODE:   cfg_q.mode   <= pwdata[1:0];
				rpq_pkg::REG_POLY8:  cfg_q.poly8  <= pwdata[7:0];
				rpq_pkg::REG_POLY16: cfg_q.poly16 <= pwdata[15:0];
				rpq_pkg::REG_POLY32: cfg_q.poly32 <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rpq_pkg::REG_MODE:   prdata = {30'd0, cfg_q.mode};
			rpq_pkg::REG_POLY8:  prdata = {24'd0, cfg_q.poly8};
			rpq_pkg::REG_POLY16: prdata = {16'd0, cfg_q.poly16};
			rpq_pkg::REG_POLY32: prdata = cfg_q.poly32;
			default:             prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/rpq_gf.sv =====
`default_nettype none
module rpq_gf (
	input  wire rpq_pkg::cfg_t               cfg,
	input  wire logic                        first,
	input  wire logic [rpq_pkg::WORD_W-1:0]  data,
	input  wire logic [rpq_pkg::WORD_W-1:0]  p_old,
	input  wire logic [rpq_pkg::WORD_W-1:0]  q_old,
	output      logic [rpq_pkg::WORD_W-1:0]  p_new,
	output      logic [rpq_pkg::WORD_W-1:0]  q_new
);

	logic [rpq_pkg::WORD_W-1:0] q_dbl;

	// multiply each packed symbol by x, reducing by the mode's polynomial
	always_comb begin
		q_dbl = '0;
		unique case (cfg.mode)
			rpq_pkg::MODE_W8: begin
				for (int k = 0; k < 4; k++) begin
					q_dbl[8*k +: 8] = {q_old[8*k +: 7], 1'b0}
						^ (q_old[8*k+7] ? cfg.poly8 : 8'd0);
				end
			end
			rpq_pkg::MODE_W16: begin
				for (int k = 0; k < 2; k++) begin
					q_dbl[16*k +: 16] = {q_old[16*k +: 15], 1'b0}
						^ (q_old[16*k+15] ? cfg.poly16 : 16'd0);
				end
			end
			default: begin
				// 32-bit symbols; the unused code 3 lands here too
				q_dbl = {q_old[30:0], 1'b0} ^ (q_old[31] ? cfg.poly32 : 32'd0);
			end
		endcase
	end

	assign p_new = first ? data : (p_old ^ data);
	assign q_new = first ? data : (q_dbl ^ data);

endmodule
`default_nettype wire
